### hw/rtl/psnb_pkg.sv
// ----------------------------------------------------------------------------
// psnb_pkg
// Shared types and codes for the point store with nearest and ball search.
// ----------------------------------------------------------------------------
package psnb_pkg;

    localparam int COORD_W = 16;
    localparam int IDX_W   = 6;
    localparam int DIST_W  = 34;
    localparam int SQ_W    = 32;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_NEAREST = 2'd1;
    localparam logic [1:0] FUNC_BALL    = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_NONE = 2'd2;

    typedef struct packed {
        logic [1:0]                 func;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [COORD_W-1:0]         radius;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  point_index;
        logic [DIST_W-1:0] dist_sq;
        logic              last;
    } t_result;

    // one slot entering the distance pipeline
    typedef struct packed {
        logic             valid;
        logic             tail;
        logic [IDX_W-1:0] idx;
    } t_scan_req;

    // one slot leaving the distance pipeline
    typedef struct packed {
        logic              valid;
        logic              tail;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dsq;
    } t_scan_beat;

endpackage

### hw/rtl/psnb_cell.sv
// ----------------------------------------------------------------------------
// psnb_cell
// One storage cell of the point ring: holds one point, loads on insert and
// takes its neighbor's point on every rotate step.
// ----------------------------------------------------------------------------
module psnb_cell (
    input  logic                           i_clk,
    input  logic                           i_shift,
    input  logic                           i_wr,
    input  logic signed [psnb_pkg::COORD_W-1:0] i_wr_x,
    input  logic signed [psnb_pkg::COORD_W-1:0] i_wr_y,
    input  logic signed [psnb_pkg::COORD_W-1:0] i_nb_x,
    input  logic signed [psnb_pkg::COORD_W-1:0] i_nb_y,
    output logic signed [psnb_pkg::COORD_W-1:0] o_x,
    output logic signed [psnb_pkg::COORD_W-1:0] o_y
);
    import psnb_pkg::*;

    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end else if (i_shift) begin
            r_x <= i_nb_x;
            r_y <= i_nb_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

### hw/rtl/psnb_dist.sv
// ----------------------------------------------------------------------------
// psnb_dist
// Squared distance pipeline: absolute differences, then squares, then the sum
// on the way out.
// ----------------------------------------------------------------------------
module psnb_dist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  psnb_pkg::t_scan_req                 i_req,
    input  logic signed [psnb_pkg::COORD_W-1:0] i_px,
    input  logic signed [psnb_pkg::COORD_W-1:0] i_py,
    input  logic signed [psnb_pkg::COORD_W-1:0] i_qx,
    input  logic signed [psnb_pkg::COORD_W-1:0] i_qy,
    output psnb_pkg::t_scan_beat                o_beat
);
    import psnb_pkg::*;

    logic signed [COORD_W:0] w_dx;
    logic signed [COORD_W:0] w_dy;
    logic [COORD_W-1:0]      n_ax;
    logic [COORD_W-1:0]      n_ay;

    t_scan_req          r_req1;
    logic [COORD_W-1:0] r_ax;
    logic [COORD_W-1:0] r_ay;
    t_scan_req          r_req2;
    logic [SQ_W-1:0]    r_sx;
    logic [SQ_W-1:0]    r_sy;

    always_comb begin
        w_dx = (COORD_W+1)'(i_qx) - (COORD_W+1)'(i_px);
        w_dy = (COORD_W+1)'(i_qy) - (COORD_W+1)'(i_py);
        n_ax = w_dx[COORD_W] ? COORD_W'(-w_dx) : w_dx[COORD_W-1:0];
        n_ay = w_dy[COORD_W] ? COORD_W'(-w_dy) : w_dy[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req1 <= '0;
            r_req2 <= '0;
        end else begin
            r_req1 <= i_req;
            r_req2 <= r_req1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax <= n_ax;
        r_ay <= n_ay;
        r_sx <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sy <= SQ_W'(r_ay) * SQ_W'(r_ay);
    end

    always_comb begin
        o_beat.valid = r_req2.valid;
        o_beat.tail  = r_req2.tail;
        o_beat.idx   = r_req2.idx;
        o_beat.dsq   = DIST_W'(r_sx) + DIST_W'(r_sy);
    end

endmodule

### hw/rtl/point_store_nearest_and_ball_search.sv
// ----------------------------------------------------------------------------
// point_store_nearest_and_ball_search
// Store of up to CAPACITY 2D points with nearest-point and radius search.
// ----------------------------------------------------------------------------
// An insert's result is registered and appears in the cycle after start;
// busy stays low. A nearest or ball query rotates the whole ring of point
// cells once, one cell per cycle, and the head cell feeds a two-register
// squared-distance pipeline; the busy time of a query does not depend on the
// fill level, and its last result appears in the same cycle that busy drops.
// Results come out one per cycle on o_strobe and cannot be held off: a ball
// query emits each match in storage order with last set on the final one,
// or one none result. The ring rotation sets the query time.
// ----------------------------------------------------------------------------
module point_store_nearest_and_ball_search #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  psnb_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_strobe,
    output psnb_pkg::t_result   o_result
);
    import psnb_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                r_state;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_issue;
    logic [1:0]                r_func;
    logic signed [COORD_W-1:0] r_qx;
    logic signed [COORD_W-1:0] r_qy;
    logic [SQ_W-1:0]           r_r2;

    logic                      r_found;
    logic [IDX_W-1:0]          r_best_i;
    logic [DIST_W-1:0]         r_best_d;

    logic                      r_out_vld;
    t_result                   r_out;

    logic                      n_found;
    logic [IDX_W-1:0]          n_best_i;
    logic [DIST_W-1:0]         n_best_d;
    logic                      n_out_vld;
    t_result                   n_out;
    logic [1:0]                n_state;
    logic [CNT_W-1:0]          n_count;
    logic [CNT_W-1:0]          n_issue;

    logic                      w_accept;
    logic                      w_ins;
    logic                      w_shift;
    t_scan_req                 w_req;
    t_scan_beat                w_beat;

    logic signed [COORD_W-1:0] w_x [CAPACITY];
    logic signed [COORD_W-1:0] w_y [CAPACITY];

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_ins    = w_accept && (i_item.func == FUNC_INSERT)
                      && (r_count < CNT_W'(CAPACITY));
    assign w_shift  = (r_state == ST_ISSUE) && (r_issue < CNT_W'(CAPACITY));

    // ring of cells; cell 0 is the head that feeds the pipeline
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        psnb_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_wr    (w_ins && (r_count == CNT_W'(k))),
            .i_wr_x  (i_item.pos_x),
            .i_wr_y  (i_item.pos_y),
            .i_nb_x  (w_x[(k + 1) % CAPACITY]),
            .i_nb_y  (w_y[(k + 1) % CAPACITY]),
            .o_x     (w_x[k]),
            .o_y     (w_y[k])
        );
    end

    always_comb begin
        w_req.valid = w_shift && (r_issue < r_count);
        w_req.tail  = (r_state == ST_ISSUE) && (r_issue == CNT_W'(CAPACITY));
        w_req.idx   = IDX_W'(r_issue);
    end

    psnb_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_px    (w_x[0]),
        .i_py    (w_y[0]),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_beat  (w_beat)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_issue   = r_issue;
        n_found   = r_found;
        n_best_i  = r_best_i;
        n_best_d  = r_best_d;
        n_out_vld = 1'b0;
        n_out     = r_out;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_item.func)
                        FUNC_INSERT: begin
                            n_out_vld         = 1'b1;
                            n_out.dist_sq     = '0;
                            n_out.last        = 1'b1;
                            if (w_ins) begin
                                n_out.status      = STAT_OK;
                                n_out.point_index = IDX_W'(r_count);
                                n_count           = r_count + 1'b1;
                            end else begin
                                n_out.status      = STAT_FULL;
                                n_out.point_index = '0;
                            end
                        end
                        FUNC_NEAREST, FUNC_BALL: begin
                            n_state = ST_ISSUE;
                            n_issue = '0;
                            n_found = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                n_issue = r_issue + 1'b1;
                if (r_issue == CNT_W'(CAPACITY)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // consume pipeline beats
        if (w_beat.valid) begin
            if (r_func == FUNC_NEAREST) begin
                if (!r_found || (w_beat.dsq < r_best_d)) begin
                    n_found  = 1'b1;
                    n_best_i = w_beat.idx;
                    n_best_d = w_beat.dsq;
                end
            end else if (w_beat.dsq <= DIST_W'(r_r2)) begin
                // flush the held match, hold the new one
                if (r_found) begin
                    n_out_vld         = 1'b1;
                    n_out.status      = STAT_OK;
                    n_out.point_index = r_best_i;
                    n_out.dist_sq     = r_best_d;
                    n_out.last        = 1'b0;
                end
                n_found  = 1'b1;
                n_best_i = w_beat.idx;
                n_best_d = w_beat.dsq;
            end
        end else if (w_beat.tail) begin
            n_out_vld  = 1'b1;
            n_out.last = 1'b1;
            if (r_found) begin
                n_out.status      = STAT_OK;
                n_out.point_index = r_best_i;
                n_out.dist_sq     = r_best_d;
            end else begin
                n_out.status      = STAT_NONE;
                n_out.point_index = '0;
                n_out.dist_sq     = '0;
            end
            n_state = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_issue   <= '0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_issue   <= n_issue;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_i <= n_best_i;
        r_best_d <= n_best_d;
        r_out    <= n_out;
        if (w_accept) begin
            r_func <= i_item.func;
            r_qx   <= i_item.pos_x;
            r_qy   <= i_item.pos_y;
            r_r2   <= SQ_W'(i_item.radius) * SQ_W'(i_item.radius);
        end
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule
